// ----- hdl/shwm_pkg.sv -----
package shwm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOSS_LIMIT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_JITTER_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LIMIT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LIMIT   = 3'd4;

  localparam logic [15:0] WINDOW_TICKS_RESET = 16'd2000;
  localparam logic [9:0]  LOSS_LIMIT_RESET   = 10'd50;
  localparam logic [23:0] JITTER_LIMIT_RESET = 24'd20000;
  localparam logic [23:0] FRAME_LIMIT_RESET  = 24'd50000;
  localparam logic [15:0] ERROR_LIMIT_RESET  = 16'd10;

  localparam logic [23:0] AVG_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [15:0] window_ticks;
    logic [9:0]  loss_limit_permille;
    logic [23:0] jitter_limit_us;
    logic [23:0] frame_limit_us;
    logic [15:0] error_limit;
  } cfg_t;

  typedef struct packed {
    logic        packet_seen;
    logic        packet_lost;
    logic [23:0] jitter_us;
    logic        decode_error;
    logic        frame_seen;
    logic [23:0] frame_time_us;
    logic        query;
    logic        tick;
  } item_t;

  typedef struct packed {
    logic [9:0]  loss_permille;
    logic [23:0] avg_jitter_us;
    logic [23:0] avg_frame_us;
    logic [31:0] error_count;
    logic        degraded;
    logic        window_end;
  } res_t;

endpackage

// ----- hdl/stream_health_window_monitor.sv -----
// Input: one word per cycle while full is low; full rises only while two result snapshots wait
// in the queue, for the divider or for the result word to be popped. Each snapshot runs the
// loss, jitter and frame divisions in order on one shared restoring divider, one quotient bit
// per cycle; the sequencer takes the next snapshot once idle and the result word is popped.
// Reset: synchronous, clears window counts and sums, empties the queue, loads default limits.
module stream_health_window_monitor #(
  parameter int COUNT_WIDTH = 32,
  parameter int SUM_WIDTH   = 56
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             packet_seen,
  input  logic                             packet_lost,
  input  logic [23:0]                      jitter_us,
  input  logic                             decode_error,
  input  logic                             frame_seen,
  input  logic [23:0]                      frame_time_us,
  input  logic                             query,
  input  logic                             tick,
  output logic                             empty,
  input  logic                             pop,
  output logic [9:0]                       loss_permille,
  output logic [23:0]                      avg_jitter_us,
  output logic [23:0]                      avg_frame_us,
  output logic [31:0]                      error_count,
  output logic                             degraded,
  output logic                             window_end,
  input  logic                             cfg_wr,
  input  logic [shwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [shwm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import shwm_pkg::*;

  localparam int SNAP_W = 4 * COUNT_WIDTH + 2 * SUM_WIDTH + 1;

  cfg_t                   cfg;
  item_t                  item;
  res_t                   res;
  logic                   res_valid;
  logic                   take;

  logic                   f_enq;
  logic [COUNT_WIDTH-1:0] f_total;
  logic [COUNT_WIDTH-1:0] f_lost;
  logic [SUM_WIDTH-1:0]   f_jsum;
  logic [SUM_WIDTH-1:0]   f_fsum;
  logic [COUNT_WIDTH-1:0] f_fcnt;
  logic [COUNT_WIDTH-1:0] f_err;
  logic                   f_wend;

  logic [COUNT_WIDTH-1:0] b_total;
  logic [COUNT_WIDTH-1:0] b_lost;
  logic [SUM_WIDTH-1:0]   b_jsum;
  logic [SUM_WIDTH-1:0]   b_fsum;
  logic [COUNT_WIDTH-1:0] b_fcnt;
  logic [COUNT_WIDTH-1:0] b_err;
  logic                   b_wend;

  logic [SNAP_W-1:0]      snap_in;
  logic [SNAP_W-1:0]      snap_out;
  logic                   q_empty;
  logic                   q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ticks        <= WINDOW_TICKS_RESET;
      cfg.loss_limit_permille <= LOSS_LIMIT_RESET;
      cfg.jitter_limit_us     <= JITTER_LIMIT_RESET;
      cfg.frame_limit_us      <= FRAME_LIMIT_RESET;
      cfg.error_limit         <= ERROR_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_WINDOW_TICKS: cfg.window_ticks        <= cfg_data[15:0];
        REG_LOSS_LIMIT:   cfg.loss_limit_permille <= cfg_data[9:0];
        REG_JITTER_LIMIT: cfg.jitter_limit_us     <= cfg_data[23:0];
        REG_FRAME_LIMIT:  cfg.frame_limit_us      <= cfg_data[23:0];
        REG_ERROR_LIMIT:  cfg.error_limit         <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign take = push && !full;

  assign item.packet_seen   = packet_seen;
  assign item.packet_lost   = packet_lost;
  assign item.jitter_us     = jitter_us;
  assign item.decode_error  = decode_error;
  assign item.frame_seen    = frame_seen;
  assign item.frame_time_us = frame_time_us;
  assign item.query         = query;
  assign item.tick          = tick;

  shwm_front #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (item),
    .window_ticks (cfg.window_ticks),
    .enq          (f_enq),
    .snap_total   (f_total),
    .snap_lost    (f_lost),
    .snap_jsum    (f_jsum),
    .snap_fsum    (f_fsum),
    .snap_fcnt    (f_fcnt),
    .snap_err     (f_err),
    .snap_wend    (f_wend)
  );

  assign snap_in = {f_wend, f_err, f_fcnt, f_fsum, f_jsum, f_lost, f_total};
  assign {b_wend, b_err, b_fcnt, b_fsum, b_jsum, b_lost, b_total} = snap_out;

  shwm_queue #(
    .WIDTH (SNAP_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_enq),
    .data_in  (snap_in),
    .pop      (q_pop),
    .data_out (snap_out),
    .full     (full),
    .empty    (q_empty)
  );

  shwm_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_total   (b_total),
    .q_lost    (b_lost),
    .q_jsum    (b_jsum),
    .q_fsum    (b_fsum),
    .q_fcnt    (b_fcnt),
    .q_err     (b_err),
    .q_wend    (b_wend),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty         = !res_valid;
  assign loss_permille = res.loss_permille;
  assign avg_jitter_us = res.avg_jitter_us;
  assign avg_frame_us  = res.avg_frame_us;
  assign error_count   = res.error_count;
  assign degraded      = res.degraded;
  assign window_end    = res.window_end;

endmodule

// ----- hdl/shwm_queue.sv -----
module shwm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] data_in,
  input  logic             pop,
  output logic [WIDTH-1:0] data_out,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign data_out = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/shwm_front.sv -----
module shwm_front #(
  parameter int COUNT_WIDTH = 32,
  parameter int SUM_WIDTH   = 56
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  shwm_pkg::item_t        item,
  input  logic [15:0]            window_ticks,
  output logic                   enq,
  output logic [COUNT_WIDTH-1:0] snap_total,
  output logic [COUNT_WIDTH-1:0] snap_lost,
  output logic [SUM_WIDTH-1:0]   snap_jsum,
  output logic [SUM_WIDTH-1:0]   snap_fsum,
  output logic [COUNT_WIDTH-1:0] snap_fcnt,
  output logic [COUNT_WIDTH-1:0] snap_err,
  output logic                   snap_wend
);

  import shwm_pkg::*;

  logic [COUNT_WIDTH-1:0] packet_total;
  logic [COUNT_WIDTH-1:0] packet_lost_total;
  logic [SUM_WIDTH-1:0]   jitter_sum;
  logic [SUM_WIDTH-1:0]   frame_sum;
  logic [COUNT_WIDTH-1:0] frame_count;
  logic [COUNT_WIDTH-1:0] error_total;
  logic [15:0]            tick_count;

  logic [SUM_WIDTH:0]     jsum_add;
  logic [SUM_WIDTH:0]     fsum_add;
  logic [15:0]            win;
  logic [16:0]            tick_inc;
  logic                   wend;

  assign jsum_add = {1'b0, jitter_sum} + (SUM_WIDTH+1)'(item.jitter_us);
  assign fsum_add = {1'b0, frame_sum} + (SUM_WIDTH+1)'(item.frame_time_us);
  assign win      = (window_ticks == 16'd0) ? 16'd1 : window_ticks;
  assign tick_inc = {1'b0, tick_count} + 17'd1;
  assign wend     = item.tick && (tick_inc >= {1'b0, win});

  always_comb begin
    snap_total = packet_total;
    snap_lost  = packet_lost_total;
    snap_jsum  = jitter_sum;
    snap_fsum  = frame_sum;
    snap_fcnt  = frame_count;
    snap_err   = error_total;
    if (item.packet_seen) begin
      if (!(&packet_total)) begin
        snap_total = packet_total + COUNT_WIDTH'(1);
      end
      if (item.packet_lost && !(&packet_lost_total)) begin
        snap_lost = packet_lost_total + COUNT_WIDTH'(1);
      end
      snap_jsum = jsum_add[SUM_WIDTH] ? '1 : jsum_add[SUM_WIDTH-1:0];
    end
    if (item.decode_error && !(&error_total)) begin
      snap_err = error_total + COUNT_WIDTH'(1);
    end
    if (item.frame_seen) begin
      if (!(&frame_count)) begin
        snap_fcnt = frame_count + COUNT_WIDTH'(1);
      end
      snap_fsum = fsum_add[SUM_WIDTH] ? '1 : fsum_add[SUM_WIDTH-1:0];
    end
  end

  assign snap_wend = wend;
  assign enq       = take && (wend || item.query);

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_total      <= '0;
      packet_lost_total <= '0;
      jitter_sum        <= '0;
      frame_sum         <= '0;
      frame_count       <= '0;
      error_total       <= '0;
      tick_count        <= '0;
    end else if (take) begin
      if (wend) begin
        packet_total      <= '0;
        packet_lost_total <= '0;
        jitter_sum        <= '0;
        frame_sum         <= '0;
        frame_count       <= '0;
        error_total       <= '0;
        tick_count        <= '0;
      end else begin
        packet_total      <= snap_total;
        packet_lost_total <= snap_lost;
        jitter_sum        <= snap_jsum;
        frame_sum         <= snap_fsum;
        frame_count       <= snap_fcnt;
        error_total       <= snap_err;
        if (item.tick) begin
          tick_count <= tick_inc[15:0];
        end
      end
    end
  end

endmodule

// ----- hdl/shwm_div.sv -----
module shwm_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic             rem_nz
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic             den_zero;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign shifted  = {rem, quo[NUM_W-1]};
  assign trial    = shifted - {1'b0, den_r};
  assign fits     = (shifted >= {1'b0, den_r});
  assign quotient = den_zero ? '0 : quo;
  assign rem_nz   = (rem != '0);

  always_ff @(posedge clk) begin
    if (start) begin
      quo      <= num;
      rem      <= '0;
      den_r    <= den;
      den_zero <= (den == '0);
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/shwm_back.sv -----
module shwm_back #(
  parameter int COUNT_WIDTH = 32,
  parameter int SUM_WIDTH   = 56
) (
  input  logic                   clk,
  input  logic                   rst,
  input  shwm_pkg::cfg_t         cfg,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  logic [COUNT_WIDTH-1:0] q_total,
  input  logic [COUNT_WIDTH-1:0] q_lost,
  input  logic [SUM_WIDTH-1:0]   q_jsum,
  input  logic [SUM_WIDTH-1:0]   q_fsum,
  input  logic [COUNT_WIDTH-1:0] q_fcnt,
  input  logic [COUNT_WIDTH-1:0] q_err,
  input  logic                   q_wend,
  output shwm_pkg::res_t         res,
  output logic                   res_valid,
  input  logic                   res_pop
);

  import shwm_pkg::*;

  localparam int NUM_W = (SUM_WIDTH > COUNT_WIDTH + 10) ? SUM_WIDTH : COUNT_WIDTH + 10;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOSS = 2'd1;
  localparam logic [1:0] ST_JIT  = 2'd2;
  localparam logic [1:0] ST_FRM  = 2'd3;

  logic [1:0]             state;
  logic [COUNT_WIDTH-1:0] total;
  logic [SUM_WIDTH-1:0]   jsum;
  logic [SUM_WIDTH-1:0]   fsum;
  logic [COUNT_WIDTH-1:0] fcnt;
  logic [COUNT_WIDTH-1:0] err;
  logic                   wend;
  logic [9:0]             loss_pm;
  logic                   loss_deg;
  logic [23:0]            avg_jit;
  logic                   jit_deg;

  logic                   div_start;
  logic [NUM_W-1:0]       div_num;
  logic [COUNT_WIDTH-1:0] div_den;
  logic                   div_busy;
  logic                   div_done;
  logic [NUM_W-1:0]       div_quo;
  logic                   div_rem_nz;

  logic [NUM_W-1:0]       lost_n;
  logic [NUM_W-1:0]       loss_num;
  logic [23:0]            quo_clamp;
  logic [63:0]            err64;
  logic                   res_load;
  logic                   frm_deg;
  logic                   err_deg;

  assign lost_n    = NUM_W'(q_lost);
  assign loss_num  = (lost_n << 10) - (lost_n << 4) - (lost_n << 3);
  assign quo_clamp = (div_quo[NUM_W-1:24] != '0) ? AVG_MAX : div_quo[23:0];
  assign err64     = 64'(err);
  assign frm_deg   = (div_quo > NUM_W'(cfg.frame_limit_us));
  assign err_deg   = (err64 > 64'(cfg.error_limit));

  assign q_pop    = (state == ST_IDLE) && !q_empty && !res_valid;
  assign res_load = (state == ST_FRM) && div_done;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      ST_IDLE: begin
        div_start = q_pop;
        div_num   = loss_num;
        div_den   = q_total;
      end
      ST_LOSS: begin
        div_start = div_done;
        div_num   = NUM_W'(jsum);
        div_den   = total;
      end
      ST_JIT: begin
        div_start = div_done;
        div_num   = NUM_W'(fsum);
        div_den   = fcnt;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  shwm_div #(
    .NUM_W (NUM_W),
    .DEN_W (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo),
    .rem_nz   (div_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      total <= q_total;
      jsum  <= q_jsum;
      fsum  <= q_fsum;
      fcnt  <= q_fcnt;
      err   <= q_err;
      wend  <= q_wend;
    end
    if ((state == ST_LOSS) && div_done) begin
      loss_pm  <= div_quo[9:0];
      loss_deg <= (total != '0) &&
                  ((div_quo > NUM_W'(cfg.loss_limit_permille)) ||
                   ((div_quo == NUM_W'(cfg.loss_limit_permille)) && div_rem_nz));
    end
    if ((state == ST_JIT) && div_done) begin
      avg_jit <= quo_clamp;
      jit_deg <= (div_quo > NUM_W'(cfg.jitter_limit_us));
    end
    if (res_load) begin
      res.loss_permille <= loss_pm;
      res.avg_jitter_us <= avg_jit;
      res.avg_frame_us  <= quo_clamp;
      res.error_count   <= (err64[63:32] != '0) ? '1 : err64[31:0];
      res.degraded      <= wend && (loss_deg || jit_deg || frm_deg || err_deg);
      res.window_end    <= wend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_LOSS;
          end
        end
        ST_LOSS: begin
          if (div_done) begin
            state <= ST_JIT;
          end
        end
        ST_JIT: begin
          if (div_done) begin
            state <= ST_FRM;
          end
        end
        ST_FRM: begin
          if (div_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !res_valid)
    else $error("result loaded over a waiting word");

  a_degraded_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.degraded || res.window_end))
    else $error("degraded flag on a query word");

  a_busy_off_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_busy)
    else $error("divider busy with sequencer idle");
`endif

endmodule
